/* design/sbpr_pkg.sv */
// Package for the six-button pad reader: result type, phase codes and axis constants.
// No dependencies; imported by sbpr_seq and six_button_pad_reader_core.
package sbpr_pkg;

    localparam logic [3:0] PHASE_IDLE   = 4'd0;
    localparam logic [3:0] PHASE_FIRST  = 4'd1;
    localparam logic [3:0] PHASE_AB     = 4'd1;
    localparam logic [3:0] PHASE_DIR    = 4'd2;
    localparam logic [3:0] PHASE_EXT    = 4'd6;
    localparam logic [3:0] PHASE_LAST   = 4'd8;

    localparam logic [7:0] SETTLE_RESET = 8'd2;

    localparam logic signed [7:0] AXIS_POS  = 8'sd127;
    localparam logic signed [7:0] AXIS_NEG  = -8'sd127;
    localparam logic signed [7:0] AXIS_ZERO = 8'sd0;

    localparam int LATCH_W = 12;

    // button latch bit positions
    localparam int BIT_A     = 0;
    localparam int BIT_B     = 1;
    localparam int BIT_C     = 2;
    localparam int BIT_X     = 3;
    localparam int BIT_Y     = 4;
    localparam int BIT_Z     = 5;
    localparam int BIT_START = 6;
    localparam int BIT_MODE  = 7;
    localparam int BIT_UP    = 8;
    localparam int BIT_DOWN  = 9;
    localparam int BIT_LEFT  = 10;
    localparam int BIT_RIGHT = 11;

    typedef struct packed {
        logic              select_level;
        logic              select_pad;
        logic              busy_res;
        logic              report_valid;
        logic              report_pad;
        logic [7:0]        buttons;
        logic signed [7:0] axis_x;
        logic signed [7:0] axis_y;
    } result_t;

endpackage

/* design/six_button_pad_reader_core.sv */
// Top level of the six-button pad reader: config register, sequencer, output skid.
// Depends on sbpr_pkg and sbpr_seq.
//
// Each input item is one timing tick carrying the request and the pad's data line
// levels; each item yields exactly one result item. An item is taken every cycle
// while item_stall is low; the sequencer state advances in the accepting cycle and the
// result is registered at that edge into the output register, or into a one-entry
// skid register when the output is held, so item_stall depends only on stored state.
// settle_ticks resets to 2, a value of 0 acts as 1, and the user must write it through
// cfg_we/cfg_data only while the block is idle; the block does not enforce this. A
// read sequence spans 8 * settle_ticks items past its start; the last carries the report.
module six_button_pad_reader_core #(
    parameter int NUM_PADS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              start_req,
    input  logic              pad_index,
    input  logic [5:0]        data_lines,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              select_level,
    output logic              select_pad,
    output logic              busy_res,
    output logic              report_valid,
    output logic              report_pad,
    output logic [7:0]        buttons,
    output logic signed [7:0] axis_x,
    output logic signed [7:0] axis_y
);
    import sbpr_pkg::*;

    logic [7:0] settle_reg;
    logic       accept;
    logic       take;
    result_t    step_result;
    result_t    out_reg;
    result_t    skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;

    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !skid_valid_reg;
    assign take       = out_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_RESET;
        else if (cfg_we)
            settle_reg <= cfg_data;
    end

    sbpr_seq #(
        .NUM_PADS (NUM_PADS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .start_req    (start_req),
        .pad_index    (pad_index),
        .data_lines   (data_lines),
        .settle_ticks (settle_reg),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
                skid_reg <= step_result;
            else
                out_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign select_level = out_reg.select_level;
    assign select_pad   = out_reg.select_pad;
    assign busy_res     = out_reg.busy_res;
    assign report_valid = out_reg.report_valid;
    assign report_pad   = out_reg.report_pad;
    assign buttons      = out_reg.buttons;
    assign axis_x       = out_reg.axis_x;
    assign axis_y       = out_reg.axis_y;

endmodule

/* design/sbpr_seq.sv */
// Select-phase sequencer and sample latch for the six-button pad reader.
// Depends on sbpr_pkg; advances one tick per accepted item and forms its result.
module sbpr_seq #(
    parameter int NUM_PADS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              start_req,
    input  logic              pad_index,
    input  logic [5:0]        data_lines,
    input  logic [7:0]        settle_ticks,
    output sbpr_pkg::result_t result
);
    import sbpr_pkg::*;

    logic [3:0]         phase_reg,  phase_next;
    logic [7:0]         hold_reg,   hold_next;
    logic [LATCH_W-1:0] latch_reg,  latch_next;
    logic               pad_reg,    pad_next;
    logic               report;
    logic               running;
    logic               phase_done;
    logic [7:0]         limit;
    logic [5:0]         pressed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_IDLE;
            hold_reg  <= 8'd0;
            latch_reg <= '0;
            pad_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            latch_reg <= latch_next;
            pad_reg   <= pad_next;
        end
    end

    assign running    = phase_reg inside {[PHASE_FIRST:PHASE_LAST]};
    assign limit      = (settle_ticks == 8'd0) ? 8'd1 : settle_ticks;
    assign phase_done = ({1'b0, hold_reg} + 9'd1) >= {1'b0, limit};
    assign pressed    = ~data_lines;

    always_comb
    begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        latch_next = latch_reg;
        pad_next   = pad_reg;
        report     = 1'b0;
        if (!running)
        begin
            phase_next = PHASE_IDLE;
            if (start_req && (32'(pad_index) < NUM_PADS))
            begin
                pad_next   = pad_index;
                phase_next = PHASE_FIRST;
                hold_next  = 8'd0;
            end
        end
        else if (phase_done)
        begin
            hold_next = 8'd0;
            case (phase_reg)
                PHASE_AB:
                begin
                    latch_next[BIT_A]     = pressed[4];
                    latch_next[BIT_START] = pressed[5];
                end
                PHASE_DIR:
                begin
                    latch_next[BIT_UP]    = pressed[0];
                    latch_next[BIT_DOWN]  = pressed[1];
                    latch_next[BIT_LEFT]  = pressed[2];
                    latch_next[BIT_RIGHT] = pressed[3];
                    latch_next[BIT_B]     = pressed[4];
                    latch_next[BIT_C]     = pressed[5];
                end
                PHASE_EXT:
                begin
                    latch_next[BIT_MODE]  = pressed[3];
                    latch_next[BIT_X]     = pressed[2];
                    latch_next[BIT_Y]     = pressed[1];
                    latch_next[BIT_Z]     = pressed[0];
                end
                default:
                begin
                end
            endcase
            if (phase_reg == PHASE_LAST)
            begin
                phase_next = PHASE_IDLE;
                report     = 1'b1;
            end
            else
            begin
                phase_next = phase_reg + 4'd1;
            end
        end
        else
        begin
            hold_next = hold_reg + 8'd1;
        end
    end

    always_comb
    begin
        result              = '0;
        result.select_level = (phase_next == PHASE_IDLE) ? 1'b1 : ~phase_next[0];
        result.select_pad   = pad_next;
        result.busy_res     = (phase_next != PHASE_IDLE);
        result.report_valid = report;
        result.axis_x       = AXIS_ZERO;
        result.axis_y       = AXIS_ZERO;
        if (report)
        begin
            result.report_pad = pad_next;
            result.buttons    = latch_next[7:0];
            if (latch_next[BIT_UP])
                result.axis_y = AXIS_NEG;
            else if (latch_next[BIT_DOWN])
                result.axis_y = AXIS_POS;
            if (latch_next[BIT_LEFT])
                result.axis_x = AXIS_NEG;
            else if (latch_next[BIT_RIGHT])
                result.axis_x = AXIS_POS;
        end
    end

endmodule

/* test/six_button_pad_reader_core_tb.sv */
// Self-checking bench for six_button_pad_reader_core: drives timing ticks with pad
// line levels, predicts select, busy and report outputs, and compares every result.
// Depends on sbpr_pkg and the core RTL only.
`timescale 1ns / 100ps

module six_button_pad_reader_core_tb;

    import sbpr_pkg::*;

    localparam int PADS        = 2;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;
    localparam int RAND_TICKS  = 50;

    typedef struct {
        bit         req;
        bit         pad;
        logic [5:0] lines;
        bit         typed;
        result_t    res;
    } tick_row_t;

    localparam result_t NO_RES      = '0;
    localparam result_t IDLE_RES    = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00,
                                        AXIS_ZERO, AXIS_ZERO};
    localparam result_t START1_RES  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00,
                                        AXIS_ZERO, AXIS_ZERO};
    localparam result_t PRESS_RES   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF,
                                        AXIS_NEG, AXIS_NEG};
    localparam result_t START0_RES  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00,
                                        AXIS_ZERO, AXIS_ZERO};
    localparam result_t RELEASE_RES = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00,
                                        AXIS_ZERO, AXIS_ZERO};

    tick_row_t dir_rows [28] = '{
        '{1'b0, 1'b0, 6'd63, 1'b1, IDLE_RES},
        '{1'b1, 1'b1, 6'd0,  1'b1, START1_RES},
        '{1'b0, 1'b0, 6'd0,  1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd0,  1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd0,  1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd0,  1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd0,  1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd0,  1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd0,  1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd0,  1'b1, PRESS_RES},
        '{1'b1, 1'b0, 6'd63, 1'b1, START0_RES},
        '{1'b0, 1'b0, 6'd63, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd63, 1'b0, NO_RES},
        '{1'b1, 1'b1, 6'd63, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd63, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd63, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd63, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd63, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd63, 1'b1, RELEASE_RES},
        '{1'b1, 1'b0, 6'd53, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd53, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd53, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd53, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd53, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd53, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd53, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd53, 1'b0, NO_RES},
        '{1'b0, 1'b0, 6'd53, 1'b0, NO_RES}
    };

    logic [7:0] settle_list [6] = '{8'd3, 8'd0, 8'd2, 8'd7, 8'd1, 8'd16};
    int         send_list   [6] = '{0, 47, 0, 31, 47, 0};
    int         recv_list   [6] = '{0, 0, 47, 31, 0, 47};

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_we       = 1'b0;
    logic [7:0]        cfg_data     = 8'd0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    logic              start_req    = 1'b0;
    logic              pad_index    = 1'b0;
    logic [5:0]        data_lines   = 6'h3F;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              select_level;
    logic              select_pad;
    logic              busy_res;
    logic              report_valid;
    logic              report_pad;
    logic [7:0]        buttons;
    logic signed [7:0] axis_x;
    logic signed [7:0] axis_y;

    // predicted pad reader state
    logic [3:0]         seq_phase   = PHASE_IDLE;
    logic [7:0]         hold_cnt    = 8'd0;
    logic [LATCH_W-1:0] btn_latch   = '0;
    logic               cur_pad     = 1'b0;
    logic [7:0]         settle_q    = SETTLE_RESET;

    result_t tick_results [$];
    int      mismatch_cnt   = 0;
    int      item_cnt       = 0;
    int      report_cnt     = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    bit      hold_req       = 1'b0;
    int      hold_left      = 0;
    int      quiet_cycles   = 0;

    six_button_pad_reader_core #(
        .NUM_PADS(PADS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .start_req    (start_req),
        .pad_index    (pad_index),
        .data_lines   (data_lines),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .select_level (select_level),
        .select_pad   (select_pad),
        .busy_res     (busy_res),
        .report_valid (report_valid),
        .report_pad   (report_pad),
        .buttons      (buttons),
        .axis_x       (axis_x),
        .axis_y       (axis_y)
    );

    always #6 clk = ~clk;

    function automatic result_t pad_read_step(bit req, bit pad, logic [5:0] lines);
        result_t r;
        int      lim;
        bit      rep;
        r   = '0;
        rep = 1'b0;
        if (seq_phase < PHASE_FIRST || seq_phase > PHASE_LAST)
        begin
            seq_phase = PHASE_IDLE;
            if (req && int'(pad) < PADS)
            begin
                cur_pad   = pad;
                seq_phase = PHASE_FIRST;
                hold_cnt  = 8'd0;
            end
        end
        else
        begin
            lim = (settle_q == 8'd0) ? 1 : int'(settle_q);
            if (int'(hold_cnt) + 1 >= lim)
            begin
                case (seq_phase)
                    PHASE_AB:
                    begin
                        btn_latch[BIT_A]     = ~lines[4];
                        btn_latch[BIT_START] = ~lines[5];
                    end
                    PHASE_DIR:
                    begin
                        btn_latch[BIT_UP]    = ~lines[0];
                        btn_latch[BIT_DOWN]  = ~lines[1];
                        btn_latch[BIT_LEFT]  = ~lines[2];
                        btn_latch[BIT_RIGHT] = ~lines[3];
                        btn_latch[BIT_B]     = ~lines[4];
                        btn_latch[BIT_C]     = ~lines[5];
                    end
                    PHASE_EXT:
                    begin
                        btn_latch[BIT_MODE]  = ~lines[3];
                        btn_latch[BIT_X]     = ~lines[2];
                        btn_latch[BIT_Y]     = ~lines[1];
                        btn_latch[BIT_Z]     = ~lines[0];
                    end
                    default: ;
                endcase
                hold_cnt = 8'd0;
                if (seq_phase == PHASE_LAST)
                begin
                    seq_phase = PHASE_IDLE;
                    rep       = 1'b1;
                end
                else
                begin
                    seq_phase = seq_phase + 4'd1;
                end
            end
            else
            begin
                hold_cnt = hold_cnt + 8'd1;
            end
        end
        if (rep)
        begin
            r.report_valid = 1'b1;
            r.report_pad   = cur_pad;
            r.buttons      = btn_latch[7:0];
            r.axis_y = btn_latch[BIT_UP]   ? AXIS_NEG :
                       btn_latch[BIT_DOWN] ? AXIS_POS : AXIS_ZERO;
            r.axis_x = btn_latch[BIT_LEFT]  ? AXIS_NEG :
                       btn_latch[BIT_RIGHT] ? AXIS_POS : AXIS_ZERO;
        end
        r.select_level = (seq_phase == PHASE_IDLE) ? 1'b1 : ~seq_phase[0];
        r.select_pad   = cur_pad;
        r.busy_res     = (seq_phase != PHASE_IDLE);
        return r;
    endfunction

    task automatic send_tick(bit req, bit pad, logic [5:0] lines,
                             bit typed = 1'b0, result_t fixed = '0);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        start_req  <= req;
        pad_index  <= pad;
        data_lines <= lines;
        do @(posedge clk); while (item_stall);
        r = pad_read_step(req, pad, lines);
        tick_results.push_back(typed ? fixed : r);
        item_cnt++;
    endtask

    task automatic send_random_tick();
        bit req;
        if (seq_phase == PHASE_IDLE)
            req = ($urandom_range(9) != 0);
        else
            req = ($urandom_range(3) == 0);
        send_tick(req, 1'($urandom_range(1)), 6'($urandom_range(63)));
    endtask

    // finish the running read, then wait until every result is back
    task automatic drain_block();
        while (seq_phase != PHASE_IDLE)
            send_tick(1'b0, 1'($urandom_range(1)), 6'($urandom_range(63)));
        item_valid <= 1'b0;
        while (tick_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic load_settle(logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settle_q = v;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : result_side
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (tick_results.size() == 0)
            begin
                $error("result with no expected item pending");
                mismatch_cnt++;
            end
            else
            begin
                want = tick_results.pop_front();
                if (want.report_valid)
                    report_cnt++;
                check_field("select_level", want.select_level, select_level);
                check_field("select_pad", want.select_pad, select_pad);
                check_field("busy_res", want.busy_res, busy_res);
                check_field("report_valid", want.report_valid, report_valid);
                check_field("report_pad", want.report_pad, report_pad);
                check_field("buttons", want.buttons, buttons);
                check_field("axis_x", int'($signed(want.axis_x)), int'(axis_x));
                check_field("axis_y", int'($signed(want.axis_y)), int'(axis_y));
            end
        end
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_settle(8'd1);
        foreach (dir_rows[i])
            send_tick(dir_rows[i].req, dir_rows[i].pad, dir_rows[i].lines,
                      dir_rows[i].typed, dir_rows[i].res);
        for (int p = 0; p < 6; p++)
        begin
            drain_block();
            load_settle(settle_list[p]);
            send_idle_pct  = send_list[p];
            recv_stall_pct = recv_list[p];
            if (p == 0)
                hold_req = 1'b1;
            repeat ((settle_list[p] > 8'd8) ? 1 : RAND_TICKS)
                send_random_tick();
        end
        drain_block();
        $display("Sent %0d ticks and saw %0d pad reports", item_cnt, report_cnt);
        $display("Settle values 1, 3, 0, 2, 7 and 16 with idle, stall and backpressure runs");
        if (mismatch_cnt == 0 && tick_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
design/sbpr_pkg.sv
design/sbpr_seq.sv
design/six_button_pad_reader_core.sv
test/six_button_pad_reader_core_tb.sv
